@@ rtl/cnalu_pkg.sv @@
// ----------------------------------------------------------------------------
// cnalu_pkg
// Shared types and opcode/condition codes for the conditional NZCV ALU.
// ----------------------------------------------------------------------------
package cnalu_pkg;

  typedef enum logic [4:0] {
    OP_NOP = 5'd0, OP_MOV = 5'd1, OP_MVN = 5'd2, OP_ADD = 5'd3, OP_ADC = 5'd4,
    OP_SUB = 5'd5, OP_SBC = 5'd6, OP_RSB = 5'd7, OP_RSC = 5'd8, OP_AND = 5'd9,
    OP_ORR = 5'd10, OP_EOR = 5'd11, OP_BIC = 5'd12, OP_CMP = 5'd13, OP_CMN = 5'd14,
    OP_TST = 5'd15, OP_TEQ = 5'd16, OP_LSL = 5'd17, OP_LSR = 5'd18, OP_ASR = 5'd19,
    OP_ROR = 5'd20, OP_MUL = 5'd21, OP_UMULL = 5'd22, OP_UMLAL = 5'd23,
    OP_SMULL = 5'd24, OP_SMLAL = 5'd25, OP_CLZ = 5'd26, OP_FLAGWRITE = 5'd27,
    OP_R28 = 5'd28, OP_R29 = 5'd29, OP_R30 = 5'd30, OP_R31 = 5'd31
  } op_t;

  localparam logic [3:0] COND_EQ = 4'd0, COND_NE = 4'd1, COND_CS = 4'd2,
    COND_CC = 4'd3, COND_MI = 4'd4, COND_PL = 4'd5, COND_VS = 4'd6,
    COND_VC = 4'd7, COND_HI = 4'd8, COND_LS = 4'd9, COND_GE = 4'd10,
    COND_LT = 4'd11, COND_GT = 4'd12, COND_LE = 4'd13, COND_AL = 4'd14,
    COND_NV = 4'd15;

  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [4:0]  operation;
    logic [3:0]  condition;
    logic        update_flags;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [31:0] accum_low;
    logic [31:0] accum_high;
  } in_word_t;

  typedef struct packed {
    logic [31:0] result_low;
    logic [31:0] result_high;
    logic        writes_dest;
    logic        condition_passed;
    logic [3:0]  flags_out;
  } out_word_t;

  // Decoded operation classes produced by the front end.
  typedef struct packed {
    logic is_addsub;   // ADD ADC CMN SUB SBC RSB RSC CMP
    logic is_sub;
    logic swap;
    logic use_cin;
    logic is_logic;    // MOV MVN AND ORR EOR BIC
    logic is_test;     // TST TEQ
    logic is_shift;
    logic is_mul;
    logic is_long;
    logic is_signed;
    logic is_acc;
    logic is_clz;
    logic is_fw;
    logic writes;
    logic set_all;     // flags written whatever the update bit says
  } dec_t;

  typedef struct packed {
    in_word_t w;
    dec_t     d;
  } qent_t;

endpackage

@@ rtl/conditional_alu_with_nzcv_flags_top.sv @@
// Conditional ALU with NZCV flags.
// Accepted words pass the queue, then execute into the output register;
// multiplies pass a product register first. Throughput: one word per cycle
//   unless out_stall; a multiply holds issue, as next flags need its product.
// Reset (rst, synchronous): flags cleared, queue and output emptied.
// ----------------------------------------------------------------------------
// conditional_alu_with_nzcv_flags_top
// Front decode with two-entry queue, back execute unit with output register.
// ----------------------------------------------------------------------------
module conditional_alu_with_nzcv_flags_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cnalu_pkg::in_word_t  in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cnalu_pkg::out_word_t out_word
);
  import cnalu_pkg::*;

  logic  q_valid, q_stall;
  qent_t q_data;

  cnalu_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_word,
    .q_valid, .q_stall, .q_data
  );

  cnalu_back u_back (
    .clk, .rst, .q_valid, .q_stall, .q_data,
    .out_valid, .out_stall, .out_word
  );

endmodule

@@ rtl/cnalu_front.sv @@
// ----------------------------------------------------------------------------
// cnalu_front
// Accepts input words, decodes the operation class and pushes into the queue.
// ----------------------------------------------------------------------------
module cnalu_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  cnalu_pkg::in_word_t in_word,
  output logic               q_valid,
  input  logic               q_stall,
  output cnalu_pkg::qent_t   q_data
);
  import cnalu_pkg::*;

  qent_t ent [QDEPTH];
  logic  [1:0] cnt;
  logic  rd_ptr, wr_ptr;
  logic  push, pop;
  dec_t  d;
  op_t   op;

  // decode
  always_comb begin
    op = op_t'(in_word.operation);
    d = '0;
    unique case (op)
      OP_MOV, OP_MVN, OP_AND, OP_ORR, OP_EOR, OP_BIC: begin
        d.is_logic = 1'b1; d.writes = 1'b1;
      end
      OP_ADD, OP_ADC: begin
        d.is_addsub = 1'b1; d.writes = 1'b1; d.use_cin = (op == OP_ADC);
      end
      OP_CMN: begin d.is_addsub = 1'b1; d.set_all = 1'b1; end
      OP_SUB, OP_SBC, OP_RSB, OP_RSC: begin
        d.is_addsub = 1'b1; d.is_sub = 1'b1; d.writes = 1'b1;
        d.swap = (op == OP_RSB) || (op == OP_RSC);
        d.use_cin = (op == OP_SBC) || (op == OP_RSC);
      end
      OP_CMP: begin d.is_addsub = 1'b1; d.is_sub = 1'b1; d.set_all = 1'b1; end
      OP_TST, OP_TEQ: begin d.is_test = 1'b1; d.set_all = 1'b1; end
      OP_LSL, OP_LSR, OP_ASR, OP_ROR: begin d.is_shift = 1'b1; d.writes = 1'b1; end
      OP_MUL: begin d.is_mul = 1'b1; d.writes = 1'b1; end
      OP_UMULL, OP_UMLAL, OP_SMULL, OP_SMLAL: begin
        d.is_mul = 1'b1; d.is_long = 1'b1; d.writes = 1'b1;
        d.is_signed = (op == OP_SMULL) || (op == OP_SMLAL);
        d.is_acc = (op == OP_UMLAL) || (op == OP_SMLAL);
      end
      OP_CLZ: begin d.is_clz = 1'b1; d.writes = 1'b1; end
      OP_FLAGWRITE: begin d.is_fw = 1'b1; d.set_all = 1'b1; end
      default: d = '0;
    endcase
  end

  assign in_stall = (cnt == 2'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt != 2'd0);
  assign pop      = q_valid && !q_stall;
  assign q_data   = ent[rd_ptr];

  // two-entry queue
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0; rd_ptr <= 1'b0; wr_ptr <= 1'b0;
    end else begin
      if (push) begin
        ent[wr_ptr] <= '{w: in_word, d: d};
        wr_ptr <= ~wr_ptr;
      end
      if (pop) rd_ptr <= ~rd_ptr;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ rtl/cnalu_back.sv @@
// ----------------------------------------------------------------------------
// cnalu_back
// Executes decoded words: condition check, datapath, flag update, output reg.
// Two stages for multiplies: raw product, then finish and flag commit.
// ----------------------------------------------------------------------------
module cnalu_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_stall,
  input  cnalu_pkg::qent_t    q_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cnalu_pkg::out_word_t out_word
);
  import cnalu_pkg::*;

  logic [3:0]  flags;
  logic        n, z, c, v, pass, cin, sf;
  in_word_t    w;
  dec_t        d;
  logic [31:0] x, y, r, sh, lg, cl;
  logic [32:0] s;
  logic        ac, av, shc;
  logic [4:0]  amt5;
  logic        big;
  logic [63:0] ror2;
  logic [5:0]  lz;
  logic [3:0]  fnext;
  logic [31:0] lo;
  logic        take;
  logic        fin_mul, direct;

  // stage-1 register for multiplies
  logic        m_valid, m_long, m_acc, m_sf;
  logic [63:0] m_prod, m_corr, m_accv;
  logic [3:0]  m_flags;
  logic [63:0] p;

  assign w   = q_data.w;
  assign d   = q_data.d;
  assign sf  = w.update_flags;
  assign n   = flags[3]; assign z = flags[2]; assign c = flags[1]; assign v = flags[0];
  assign cin = c;

  // condition
  always_comb begin
    unique case (w.condition)
      COND_EQ: pass = z;
      COND_NE: pass = !z;
      COND_CS: pass = c;
      COND_CC: pass = !c;
      COND_MI: pass = n;
      COND_PL: pass = !n;
      COND_VS: pass = v;
      COND_VC: pass = !v;
      COND_HI: pass = c && !z;
      COND_LS: pass = !c || z;
      COND_GE: pass = (n == v);
      COND_LT: pass = (n != v);
      COND_GT: pass = !z && (n == v);
      COND_LE: pass = z || (n != v);
      COND_AL: pass = 1'b1;
      default: pass = 1'b0;
    endcase
  end

  // add / subtract
  always_comb begin
    x = d.swap ? w.operand_b : w.operand_a;
    y = d.swap ? w.operand_a : w.operand_b;
    if (d.is_sub) s = {1'b0, x} + {1'b0, ~y} + 33'(d.use_cin ? cin : 1'b1);
    else          s = {1'b0, x} + {1'b0, y} + 33'(d.use_cin & cin);
    ac = s[32];
    av = d.is_sub ? ((x[31] ^ y[31]) & (x[31] ^ s[31]))
                  : (~(x[31] ^ y[31]) & (x[31] ^ s[31]));
  end

  // logic ops
  always_comb begin
    unique case (op_t'(w.operation))
      OP_MVN:  lg = ~w.operand_a;
      OP_AND:  lg = w.operand_a & w.operand_b;
      OP_ORR:  lg = w.operand_a | w.operand_b;
      OP_EOR:  lg = w.operand_a ^ w.operand_b;
      OP_BIC:  lg = w.operand_a & ~w.operand_b;
      OP_TST:  lg = w.operand_a & w.operand_b;
      OP_TEQ:  lg = w.operand_a ^ w.operand_b;
      default: lg = w.operand_a;
    endcase
  end

  // shifter
  always_comb begin
    amt5 = w.operand_b[4:0];
    big  = |w.operand_b[31:5];
    ror2 = {w.operand_a, w.operand_a} >> amt5;
    sh   = w.operand_a;
    shc  = cin;
    if (w.operand_b != 32'd0) begin
      unique case (op_t'(w.operation))
        OP_LSL: begin
          if (big) begin sh = '0; shc = 1'b0; end
          else begin
            // bit 32-amt, taken modulo 32
            sh = w.operand_a << amt5; shc = w.operand_a[5'd0 - amt5];
          end
        end
        OP_LSR: begin
          if (big) begin sh = '0; shc = 1'b0; end
          else begin sh = w.operand_a >> amt5; shc = w.operand_a[amt5 - 5'd1]; end
        end
        OP_ASR: begin
          if (big) begin sh = {32{w.operand_a[31]}}; shc = w.operand_a[31]; end
          else begin
            sh = 32'($signed(w.operand_a) >>> amt5); shc = w.operand_a[amt5 - 5'd1];
          end
        end
        default: begin
          sh = ror2[31:0]; shc = ror2[31];
        end
      endcase
    end
  end

  // leading zeros: priority search
  always_comb begin
    lz = 6'd32;
    for (int i = 0; i < 32; i++) if (w.operand_a[i]) lz = 6'(31 - i);
    cl = {26'd0, lz};
  end

  // results and flags for words that do not issue a multiply
  always_comb begin
    lo = '0;
    fnext = flags;
    r = d.is_addsub ? s[31:0] : (d.is_shift ? sh : lg);
    if (d.is_addsub) begin
      lo = r;
      if (sf || d.set_all) fnext = {r[31], r == 0, ac, av};
    end else if (d.is_logic) begin
      lo = lg;
      if (sf) fnext = {lg[31], lg == 0, flags[1:0]};
    end else if (d.is_test) begin
      fnext = {lg[31], lg == 0, 1'b0, v};
    end else if (d.is_shift) begin
      lo = sh;
      if (sf) fnext = {sh[31], sh == 0, shc, v};
    end else if (d.is_clz) begin
      lo = cl;
    end else if (d.is_fw) begin
      fnext = w.operand_a[31:28];
    end
    if (!d.writes) lo = '0;
  end

  // Stage 1 holds the raw product; it may advance when stage 2 is free.
  logic s2_free;
  assign s2_free = !out_valid || !out_stall;
  // A multiply in stage 1 blocks new words, since flags depend on it.
  assign take    = q_valid && s2_free && !m_valid;
  assign q_stall = !take;

  // output register loads from a finished multiply or a word that issues no multiply
  assign fin_mul = m_valid && s2_free;
  assign direct  = take && !(pass && d.is_mul);

  always_comb begin
    p = m_prod - (m_long ? m_corr : 64'd0) + (m_acc ? m_accv : 64'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0; out_valid <= 1'b0; m_valid <= 1'b0;
    end else begin
      out_valid <= fin_mul || direct || (out_valid && out_stall);
      if (fin_mul) begin
        // finish multiply
        m_valid <= 1'b0;
        out_word.result_low  <= p[31:0];
        out_word.result_high <= m_long ? p[63:32] : 32'd0;
        out_word.writes_dest <= 1'b1;
        out_word.condition_passed <= 1'b1;
        if (m_sf) begin
          out_word.flags_out <= m_long ? {p[63], p == 0, m_flags[1:0]}
                                       : {p[31], p[31:0] == 0, m_flags[1:0]};
          flags <= m_long ? {p[63], p == 0, m_flags[1:0]}
                          : {p[31], p[31:0] == 0, m_flags[1:0]};
        end else begin
          out_word.flags_out <= m_flags;
        end
      end else if (take) begin
        if (pass && d.is_mul) begin
          m_valid <= 1'b1;
          m_prod  <= 64'(w.operand_a) * 64'(w.operand_b);
          m_corr  <= d.is_signed ?
                     (({32'd0, w.operand_a[31] ? w.operand_b : 32'd0} +
                       {32'd0, w.operand_b[31] ? w.operand_a : 32'd0}) << 32) : 64'd0;
          m_long  <= d.is_long;
          m_acc   <= d.is_acc;
          m_accv  <= {w.accum_high, w.accum_low};
          m_sf    <= sf;
          m_flags <= flags;
        end else begin
          out_word.result_low  <= pass ? lo : 32'd0;
          out_word.result_high <= '0;
          out_word.writes_dest <= pass && d.writes;
          out_word.condition_passed <= pass;
          out_word.flags_out <= pass ? fnext : flags;
          if (pass) flags <= fnext;
        end
      end
    end
  end

endmodule

@@ bench/tb_conditional_alu_with_nzcv_flags_top.sv @@
// ----------------------------------------------------------------------------
// tb_conditional_alu_with_nzcv_flags_top
// Self-checking bench for the conditional NZCV ALU: a directed pass over the
// operations, conditions and shift corner cases, then random words with
// bursty input and random output stalls. Results are checked in order against
// a behavioral flag-tracking predictor.
// ----------------------------------------------------------------------------
module tb_conditional_alu_with_nzcv_flags_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cnalu_pkg::*;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  in_word_t  pending_words[$];
  out_word_t expected_results[$];
  logic [3:0] model_flags;
  int        error_count = 0;
  bit        hold_off;
  bit        sender_pause;
  int        burst_left;
  int        gap_left;
  int        stall_left;
  int        free_left;

  conditional_alu_with_nzcv_flags_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Condition test against the current flags.
  function automatic bit cond_holds(logic [3:0] c, logic [3:0] f);
    bit n, z, cy, v;
    n = f[3]; z = f[2]; cy = f[1]; v = f[0];
    case (c)
      COND_EQ: return z;
      COND_NE: return !z;
      COND_CS: return cy;
      COND_CC: return !cy;
      COND_MI: return n;
      COND_PL: return !n;
      COND_VS: return v;
      COND_VC: return !v;
      COND_HI: return cy && !z;
      COND_LS: return !cy || z;
      COND_GE: return n == v;
      COND_LT: return n != v;
      COND_GT: return !z && (n == v);
      COND_LE: return z || (n != v);
      COND_AL: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [1:0] nz_bits(logic [31:0] r);
    return {r[31], r == 32'd0};
  endfunction

  // Compute the result word and advance the tracked flags.
  function automatic out_word_t alu_predict(in_word_t w);
    out_word_t  o;
    logic [3:0] f;
    logic [32:0] s;
    logic [31:0] x, y, r, vt;
    logic [63:0] p;
    logic [5:0]  k;
    bit cin, nob, cy;
    op_t op;
    o = '0;
    f = model_flags;
    cin = f[1];
    op = op_t'(w.operation);
    o.condition_passed = cond_holds(w.condition, f);
    if (o.condition_passed) begin
      case (op)
        OP_MOV, OP_MVN, OP_AND, OP_ORR, OP_EOR, OP_BIC: begin
          case (op)
            OP_MOV: r = w.operand_a;
            OP_MVN: r = ~w.operand_a;
            OP_AND: r = w.operand_a & w.operand_b;
            OP_ORR: r = w.operand_a | w.operand_b;
            OP_EOR: r = w.operand_a ^ w.operand_b;
            default: r = w.operand_a & ~w.operand_b;
          endcase
          o.result_low = r; o.writes_dest = 1'b1;
          if (w.update_flags) f[3:2] = nz_bits(r);
        end
        OP_ADD, OP_ADC, OP_CMN: begin
          s = {1'b0, w.operand_a} + {1'b0, w.operand_b} + ((op == OP_ADC && cin) ? 33'd1 : 33'd0);
          r = s[31:0];
          vt = ~(w.operand_a ^ w.operand_b) & (w.operand_a ^ r);
          if (op != OP_CMN) begin o.result_low = r; o.writes_dest = 1'b1; end
          if (w.update_flags || op == OP_CMN)
            f = {nz_bits(r), s[32], vt[31]};
        end
        OP_SUB, OP_SBC, OP_RSB, OP_RSC, OP_CMP: begin
          x = w.operand_a; y = w.operand_b;
          if (op == OP_RSB || op == OP_RSC) begin x = w.operand_b; y = w.operand_a; end
          nob = (op == OP_SBC || op == OP_RSC) ? cin : 1'b1;
          r = x - y - (nob ? 32'd0 : 32'd1);
          vt = (x ^ y) & (x ^ r);
          if (op != OP_CMP) begin o.result_low = r; o.writes_dest = 1'b1; end
          if (w.update_flags || op == OP_CMP)
            f = {nz_bits(r), nob ? (x >= y) : ({1'b0, x} >= {1'b0, y} + 33'd1),
                 vt[31]};
        end
        OP_TST, OP_TEQ: begin
          r = (op == OP_TST) ? (w.operand_a & w.operand_b) : (w.operand_a ^ w.operand_b);
          f = {nz_bits(r), 1'b0, f[0]};
        end
        OP_LSL, OP_LSR, OP_ASR, OP_ROR: begin
          x = w.operand_a; cy = cin; r = x;
          if (w.operand_b != 32'd0) begin
            k = (w.operand_b >= 32) ? 6'd32 : w.operand_b[5:0];
            case (op)
              OP_LSL: if (k == 32) begin cy = 1'b0; r = 0; end
                      else begin cy = x[32 - k]; r = x << k; end
              OP_LSR: if (k == 32) begin cy = 1'b0; r = 0; end
                      else begin cy = x[k - 1]; r = x >> k; end
              OP_ASR: if (k == 32) begin cy = x[31]; r = {32{x[31]}}; end
                      else begin cy = x[k - 1]; r = $signed(x) >>> k; end
              default: begin
                k = {1'b0, w.operand_b[4:0]};
                if (k != 0) r = (x >> k) | (x << (32 - k));
                cy = r[31];
              end
            endcase
          end
          o.result_low = r; o.writes_dest = 1'b1;
          if (w.update_flags) f = {nz_bits(r), cy, f[0]};
        end
        OP_MUL: begin
          r = w.operand_a * w.operand_b;
          o.result_low = r; o.writes_dest = 1'b1;
          if (w.update_flags) f[3:2] = nz_bits(r);
        end
        OP_UMULL, OP_UMLAL, OP_SMULL, OP_SMLAL: begin
          if (op == OP_SMULL || op == OP_SMLAL)
            p = $signed({{32{w.operand_a[31]}}, w.operand_a}) *
                $signed({{32{w.operand_b[31]}}, w.operand_b});
          else
            p = {32'd0, w.operand_a} * {32'd0, w.operand_b};
          if (op == OP_UMLAL || op == OP_SMLAL) p = p + {w.accum_high, w.accum_low};
          o.result_low = p[31:0]; o.result_high = p[63:32]; o.writes_dest = 1'b1;
          if (w.update_flags) f[3:2] = {p[63], p == 64'd0};
        end
        OP_CLZ: begin
          r = 32;
          for (int i = 31; i >= 0; i--)
            if (w.operand_a[i]) begin r = 31 - i; break; end
          o.result_low = r; o.writes_dest = 1'b1;
        end
        OP_FLAGWRITE: f = w.operand_a[31:28];
        default: ;
      endcase
      model_flags = f;
    end
    o.flags_out = model_flags;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    error_count++;
  endtask

  function automatic in_word_t make_word(op_t op, logic [3:0] c, bit sf,
                                         logic [31:0] a, logic [31:0] b);
    in_word_t w;
    w.operation = op; w.condition = c; w.update_flags = sf;
    w.operand_a = a; w.operand_b = b;
    w.accum_low = $urandom; w.accum_high = $urandom;
    return w;
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000 ^ $urandom_range(0, 3);
      3: return $urandom_range(0, 40);
      default: return $urandom;
    endcase
  endfunction

  // Directed sweep picks an operation per condition so flags keep moving.
  function automatic op_t OP_ADDS_OR(int c);
    return (c % 3 == 0) ? OP_ADD : (c % 3 == 1) ? OP_SUB : OP_FLAGWRITE;
  endfunction

  // Driver: bursts of words with random gaps; holds payload while stalled.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
      model_flags = 4'd0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid && !in_stall) expected_results.push_back(alu_predict(in_word));
      if (sender_pause || pending_words.size() == 0) begin
        in_valid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else begin
        in_word <= pending_words.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Monitor: random stall pattern, checks each accepted result.
  always @(posedge clk) begin
    out_word_t e;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      free_left <= 20;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result",
                          {out_word.result_high, out_word.result_low}, 64'd0);
        end else begin
          e = expected_results.pop_front();
          if (out_word.result_low !== e.result_low)
            report_mismatch("result_low", 64'(out_word.result_low), 64'(e.result_low));
          if (out_word.result_high !== e.result_high)
            report_mismatch("result_high", 64'(out_word.result_high),
                            64'(e.result_high));
          if (out_word.writes_dest !== e.writes_dest)
            report_mismatch("writes_dest", 64'(out_word.writes_dest),
                            64'(e.writes_dest));
          if (out_word.condition_passed !== e.condition_passed)
            report_mismatch("condition_passed", 64'(out_word.condition_passed),
                            64'(e.condition_passed));
          if (out_word.flags_out !== e.flags_out)
            report_mismatch("flags_out", 64'(out_word.flags_out), 64'(e.flags_out));
        end
      end
      if (hold_off) begin
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (free_left > 0) begin
        free_left <= free_left - 1;
        out_stall <= 1'b0;
      end else begin
        stall_left <= $urandom_range(0, 4);
        free_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(0, 5);
        out_stall <= 1'b0;
      end
    end
  end

  // Long receiver hold-off while the sender keeps offering words.
  initial begin
    hold_off = 1'b0;
    wait (expected_results.size() > 0 && !rst);
    repeat (150) @(posedge clk);
    hold_off = 1'b1;
    repeat (60) @(posedge clk);
    hold_off = 1'b0;
  end

  // Stimulus and end of run.
  initial begin
    in_word_t w;
    logic [31:0] amts[8];
    amts = '{0, 1, 31, 32, 33, 64, 32'hFFFF_FFFF, 16};
    rst = 1'b1;
    sender_pause = 0;
    pending_words.push_back(make_word(OP_FLAGWRITE, COND_AL, 1'b0, 32'hF000_0000, 32'd0));
    pending_words.push_back(make_word(OP_ADD, COND_NV, 1'b1, 32'd1, 32'd1));
    for (int c = 0; c < 16; c++)
      pending_words.push_back(make_word(OP_ADDS_OR(c), c[3:0], 1'b1, 32'h7FFF_FFFF,
                                        32'(c)));
    for (int i = 0; i < 8; i++)
      pending_words.push_back(make_word(op_t'(OP_LSL + (i % 4)), COND_AL, 1'b1,
                                        32'h8000_0001, amts[i]));
    for (int o = 0; o < 32; o++)
      pending_words.push_back(make_word(op_t'(o), COND_AL, o[0], 32'hFFFF_FFFF,
                                        32'h8000_0000));
    pending_words.push_back(make_word(OP_CLZ, COND_AL, 1'b1, 32'd0, 32'd0));
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < 490; i++) begin
      w = make_word(op_t'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                       : $urandom_range(1, 27)),
                    ($urandom_range(0, 2) == 0) ? COND_AL : 4'($urandom_range(0, 15)),
                    1'($urandom_range(0, 1)), rand_operand(), rand_operand());
      if (w.operation >= OP_LSL && w.operation <= OP_ROR && $urandom_range(0, 2) != 0)
        w.operand_b = $urandom_range(0, 40);
      pending_words.push_back(w);
      if (i == 300) begin
        wait (pending_words.size() == 0 && !(in_valid && in_stall));
        @(posedge clk);
        sender_pause = 1'b1;
        wait (expected_results.size() == 0 && !in_valid);
        repeat (5) @(posedge clk);
        sender_pause = 1'b0;
      end
    end
    wait (pending_words.size() == 0);
    @(posedge clk);
    wait (!in_valid);
    wait (expected_results.size() == 0);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
